// ----- sv/atp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atp_pkg: shared definitions for the animated test pattern pixel block
// Widths, register indexes, pattern constants and the interface types used
// between the top level and the reciprocal divider.
// ----------------------------------------------------------------------------
package atp_pkg;

    // Largest usable frame dimension.
    localparam int MAX_DIM = 2048;

    // Configuration register indexes.
    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_ROW_STRIDE   = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [11:0] RST_FRAME_WIDTH  = 12'd320;
    localparam logic [11:0] RST_FRAME_HEIGHT = 12'd240;
    localparam logic [12:0] RST_ROW_STRIDE   = 13'd320;

    // Fixed triangle waves: disc shading and ring ripple.
    // The reciprocal is floor(2^19 / half).
    localparam logic [12:0] SHADE_PERIOD = 13'd180;
    localparam logic [11:0] SHADE_HALF   = 12'd90;
    localparam logic [18:0] SHADE_RECIP  = 19'd5825;
    localparam logic [12:0] RIP_PERIOD   = 13'd120;
    localparam logic [11:0] RIP_HALF     = 12'd60;
    localparam logic [18:0] RIP_RECIP    = 19'd8738;

    // Multiple of the shading period that keeps its phase argument positive.
    localparam logic signed [18:0] SHADE_BIAS = 19'sd2160;
    // Bias that keeps the glow argument positive; removed again by its residue.
    localparam logic [17:0] GLOW_BIAS = 18'd32768;

    // Reciprocal divider: steps per division and job dividends.
    localparam int          DIV_STEPS    = 20;
    localparam logic [19:0] DIV_NUM_WAVE = 20'h80000;
    localparam logic [19:0] DIV_NUM_BIAS = 20'h08000;

    // Request and response of the serial divider.
    typedef struct packed {
        logic        start;
        logic [19:0] dividend;
        logic [12:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [19:0] quot;
        logic [12:0] rem;
    } t_div_rsp;

    // Per-pixel side information carried next to the wave units.
    typedef struct packed {
        logic        chk;
        logic        in_disc;
        logic        inring;
        logic [22:0] addr;
    } t_side;

    // Clamp a frame dimension into the range 2 .. MAX_DIM.
    function automatic logic [11:0] clamp_dim(input logic [11:0] v);
        logic [11:0] r;
        if (v < 12'd2) begin
            r = 12'd2;
        end else if (v > 12'(MAX_DIM)) begin
            r = 12'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- sv/atp_recip.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atp_recip: serial restoring divider
// Divides a 20-bit dividend by a 13-bit divisor, one quotient bit per cycle,
// and pulses done when quotient and remainder are ready.
// ----------------------------------------------------------------------------
module atp_recip
    import atp_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [19:0] r_dvd;
    logic [13:0] r_rem;
    logic [12:0] r_dsr;
    logic [13:0] n_rem;
    logic        n_bit;
    logic [13:0] shifted;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb begin
        shifted = {r_rem[12:0], r_dvd[19]};
        if (shifted >= {1'b0, r_dsr}) begin
            n_rem = shifted - {1'b0, r_dsr};
            n_bit = 1'b1;
        end else begin
            n_rem = shifted;
            n_bit = 1'b0;
        end
    end

    // Control: step count and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend register collects the quotient bits.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_rem <= '0;
            r_dsr <= i_req.divisor;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[18:0], n_bit};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_dvd;
    assign o_rsp.rem  = r_rem[12:0];

endmodule

// ----- sv/atp_tri.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atp_tri: pipelined triangle wave unit
// Eight register stages: residue by reciprocal multiply and correction,
// phase offset and fold, then scaling to 0..255 by the same reciprocal.
// ----------------------------------------------------------------------------
module atp_tri
    import atp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [17:0] i_value,
    input  logic [12:0] i_period,
    input  logic [11:0] i_half,
    input  logic [18:0] i_recip,
    input  logic [12:0] i_offset,
    output logic        o_valid,
    output logic [7:0]  o_wave
);

    logic [7:0]  r_vld;
    logic [17:0] r_a_v;
    logic [15:0] r_b_q;
    logic [17:0] r_b_v;
    logic [17:0] r_c_p;
    logic [17:0] r_c_v;
    logic [12:0] r_d_rem;
    logic [11:0] r_e_ph;
    logic [7:0]  r_f_q;
    logic [18:0] r_f_n;
    logic [18:0] r_g_p;
    logic [18:0] r_g_n;
    logic [7:0]  r_g_q;
    logic [7:0]  r_h_w;

    logic [34:0] prod_b;
    logic [28:0] prod_c;
    logic [13:0] rem_d;
    logic [13:0] off_e;
    logic [12:0] wrap_e;
    logic [12:0] ph_e;
    logic [18:0] num_f;
    logic [37:0] prod_f;
    logic [19:0] prod_g;
    logic [18:0] rem_h;

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[6:0], i_valid};
        end
    end

    // Residue stages: quotient estimate, product, one correcting subtract.
    assign prod_b = r_a_v * i_recip[18:2];
    assign prod_c = r_b_q * i_period;
    always_comb begin
        rem_d = 14'(r_c_v - r_c_p);
        if (rem_d >= {1'b0, i_period}) begin
            rem_d = rem_d - {1'b0, i_period};
        end
    end

    // Remove the argument bias, wrap, and fold the upper half back down.
    always_comb begin
        off_e = {1'b0, r_d_rem} - {1'b0, i_offset};
        if (off_e[13]) begin
            wrap_e = off_e[12:0] + i_period;
        end else begin
            wrap_e = off_e[12:0];
        end
        if (wrap_e > {1'b0, i_half}) begin
            ph_e = i_period - wrap_e;
        end else begin
            ph_e = wrap_e;
        end
    end

    // Scaling stages: phase * 255 / half with one correcting step.
    assign num_f  = 19'({r_e_ph, 8'd0} - {8'd0, r_e_ph});
    assign prod_f = num_f * i_recip;
    assign prod_g = r_f_q * i_half;
    assign rem_h  = r_g_n - r_g_p;

    always_ff @(posedge i_clk) begin
        r_a_v   <= i_value;
        r_b_q   <= prod_b[33:18];
        r_b_v   <= r_a_v;
        r_c_p   <= prod_c[17:0];
        r_c_v   <= r_b_v;
        r_d_rem <= rem_d[12:0];
        r_e_ph  <= ph_e[11:0];
        r_f_q   <= prod_f[26:19];
        r_f_n   <= num_f;
        r_g_p   <= prod_g[18:0];
        r_g_n   <= r_f_n;
        r_g_q   <= r_f_q;
        r_h_w   <= (rem_h >= {7'd0, i_half}) ? r_g_q + 8'd1 : r_g_q;
    end

    assign o_valid = r_vld[7];
    assign o_wave  = r_h_w;

endmodule

// ----- sv/animated_test_pattern_pixel_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// animated_test_pattern_pixel_top: animated RGB565 test pattern generator
// Computes one pixel color and its buffer address per accepted coordinate.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock while not busy: a beat is accepted at
// each edge with start high and busy low, and its result is on o_pixel_value
// and o_pixel_address with o_valid high for one cycle, after the input beat
// register, the wave unit stages and the result register. The receiver cannot
// stall, so the pipeline never holds. After reset and after every
// configuration write, busy stays high while a serial divider forms three
// reciprocal and residue terms of the frame size, one quotient bit per cycle;
// pixels are then taken back to back. Configuration writes are always ready.
module animated_test_pattern_pixel_top
    import atp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [10:0] i_pixel_x,
    input  logic [10:0] i_pixel_y,
    input  logic [14:0] i_frame_tick,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    output logic        o_valid,
    output logic [15:0] o_pixel_value,
    output logic [22:0] o_pixel_address
);

    typedef enum logic [4:0] {
        SQ_START = 5'b00001,
        SQ_W     = 5'b00010,
        SQ_H     = 5'b00100,
        SQ_K     = 5'b01000,
        SQ_IDLE  = 5'b10000
    } t_seq_state;

    t_seq_state r_state, n_state;

    // Configuration registers and derived frame terms.
    logic [11:0] r_fw, r_fh;
    logic [12:0] r_stride;
    logic [11:0] n_cw, n_ch;
    logic [11:0] r_cw, r_ch;
    logic [10:0] r_cx, r_cy;
    logic [9:0]  r_rad, r_ring;
    logic [7:0]  r_h12;
    logic [19:0] r_rad2, r_ring2;
    logic [18:0] r_rw, r_rh;
    logic [12:0] r_kh;
    logic [23:0] h12_prod;

    t_div_req div_req;
    t_div_rsp div_rsp;
    logic     cfg_wr;

    // Pipeline registers.
    logic        r_v0;
    logic [10:0] r_s0_x, r_s0_y;
    logic [14:0] r_s0_t;
    logic signed [12:0] r_s1_dx, r_s1_dy;
    logic [15:0] r_s1_a;
    logic [10:0] r_s1_y, r_s1_x;
    logic [23:0] r_s1_ap;
    logic [22:0] r_s2_sqx, r_s2_sqy;
    logic        r_s2_chk, r_s3_chk;
    logic [22:0] r_s2_addr, r_s3_addr;
    logic [23:0] r_s3_d2;
    t_side       r_side [0:4];

    logic signed [12:0] dx0, dy0;
    logic [17:0] vb, vg, vs, vr;
    logic signed [18:0] vs_s;
    logic signed [25:0] sqx, sqy;
    logic [31:0] qa_prod, qy_prod;
    logic [23:0] addr_sum;

    logic        w_base_vld, w_glow_vld, w_shade_vld, w_rip_vld;
    logic [7:0]  w_base, w_glow, w_shade, w_rip;
    logic [15:0] base5_p, base3_p, shade5_p;
    logic [7:0]  col_r, col_g, col_b;

    assign cfg_wr      = i_cfg_valid & o_cfg_ready;
    assign o_cfg_ready = 1'b1;
    assign busy        = (r_state != SQ_IDLE);
    assign n_cw        = clamp_dim(r_fw);
    assign n_ch        = clamp_dim(r_fh);

    // Configuration registers and the setup sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw     <= RST_FRAME_WIDTH;
            r_fh     <= RST_FRAME_HEIGHT;
            r_stride <= RST_ROW_STRIDE;
            r_state  <= SQ_START;
        end else begin
            r_state <= n_state;
            if (cfg_wr) begin
                case (i_cfg_index)
                    CFG_FRAME_WIDTH:  r_fw     <= i_cfg_data[11:0];
                    CFG_FRAME_HEIGHT: r_fh     <= i_cfg_data[11:0];
                    CFG_ROW_STRIDE:   r_stride <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Setup jobs: 2^19 / width, 2^19 / height, then 2^15 mod (2 * height).
    always_comb begin
        n_state          = r_state;
        div_req.start    = 1'b0;
        div_req.dividend = DIV_NUM_WAVE;
        div_req.divisor  = {1'b0, n_cw};
        case (r_state)
            SQ_START: begin
                div_req.start = 1'b1;
                n_state       = SQ_W;
            end
            SQ_W: begin
                if (div_rsp.done) begin
                    div_req.start   = 1'b1;
                    div_req.divisor = {1'b0, n_ch};
                    n_state         = SQ_H;
                end
            end
            SQ_H: begin
                if (div_rsp.done) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_NUM_BIAS;
                    div_req.divisor  = {n_ch, 1'b0};
                    n_state          = SQ_K;
                end
            end
            SQ_K: begin
                if (div_rsp.done) begin
                    n_state = SQ_IDLE;
                end
            end
            SQ_IDLE: ;
            default: n_state = SQ_START;
        endcase
        if (cfg_wr) begin
            n_state = SQ_START;
        end
    end

    // Capture the divider results for each job.
    always_ff @(posedge i_clk) begin
        if (div_rsp.done) begin
            if (r_state == SQ_W) begin
                r_rw <= div_rsp.quot[18:0];
            end
            if (r_state == SQ_H) begin
                r_rh <= div_rsp.quot[18:0];
            end
            if (r_state == SQ_K) begin
                r_kh <= div_rsp.rem;
            end
        end
    end

    atp_recip u_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Derived frame terms are registered from the clamped frame size.
    assign h12_prod = r_ch * 12'd2731;
    always_ff @(posedge i_clk) begin
        r_cw    <= n_cw;
        r_ch    <= n_ch;
        r_cx    <= r_cw[11:1];
        r_cy    <= r_ch[11:1];
        r_rad   <= (r_cw < r_ch) ? r_cw[11:2] : r_ch[11:2];
        r_h12   <= h12_prod[22:15];
        r_ring  <= r_rad + {2'd0, r_h12};
        r_rad2  <= r_rad * r_rad;
        r_ring2 <= r_ring * r_ring;
    end

    // Input beat register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0_x <= i_pixel_x;
        r_s0_y <= i_pixel_y;
        r_s0_t <= i_frame_tick;
    end

    // Wave arguments, all brought into a positive range.
    assign dx0  = $signed({2'b0, r_s0_x}) - $signed({2'b0, r_cx});
    assign dy0  = $signed({2'b0, r_s0_y}) - $signed({2'b0, r_cy});
    assign vb   = {7'd0, r_s0_x} + {2'd0, r_s0_t, 1'b0};
    assign vg   = {7'd0, r_s0_y} + GLOW_BIAS - {3'd0, r_s0_t};
    assign vs_s = 19'(dx0) + 19'(dy0) + $signed({2'b0, r_s0_t, 2'b0}) + SHADE_BIAS;
    assign vs   = vs_s[17:0];
    assign vr   = {3'd0, r_s0_t} + {2'd0, r_s0_t, 1'b0} + {7'd0, r_s0_x};

    atp_tri u_base (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (r_v0),
        .i_value (vb), .i_period ({r_cw, 1'b0}), .i_half (r_cw),
        .i_recip (r_rw), .i_offset (13'd0),
        .o_valid (w_base_vld), .o_wave (w_base)
    );

    atp_tri u_glow (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (r_v0),
        .i_value (vg), .i_period ({r_ch, 1'b0}), .i_half (r_ch),
        .i_recip (r_rh), .i_offset (r_kh),
        .o_valid (w_glow_vld), .o_wave (w_glow)
    );

    atp_tri u_shade (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (r_v0),
        .i_value (vs), .i_period (SHADE_PERIOD), .i_half (SHADE_HALF),
        .i_recip (SHADE_RECIP), .i_offset (13'd0),
        .o_valid (w_shade_vld), .o_wave (w_shade)
    );

    atp_tri u_rip (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_valid (r_v0),
        .i_value (vr), .i_period (RIP_PERIOD), .i_half (RIP_HALF),
        .i_recip (RIP_RECIP), .i_offset (13'd0),
        .o_valid (w_rip_vld), .o_wave (w_rip)
    );

    // Distance, checkerboard parity and address, in step with the wave units.
    assign sqx      = r_s1_dx * r_s1_dx;
    assign sqy      = r_s1_dy * r_s1_dy;
    assign qa_prod  = r_s1_a * 16'd58255;
    assign qy_prod  = {5'd0, r_s1_y} * 16'd58255;
    assign addr_sum = r_s1_ap + {13'd0, r_s1_x};

    always_ff @(posedge i_clk) begin
        r_s1_dx   <= dx0;
        r_s1_dy   <= dy0;
        r_s1_a    <= {5'd0, r_s0_x} + {1'b0, r_s0_t};
        r_s1_y    <= r_s0_y;
        r_s1_x    <= r_s0_x;
        r_s1_ap   <= r_s0_y * r_stride;
        r_s2_sqx  <= sqx[22:0];
        r_s2_sqy  <= sqy[22:0];
        r_s2_chk  <= (qa_prod[20] == qy_prod[20]);
        r_s2_addr <= addr_sum[22:0];
        r_s3_d2   <= {1'b0, r_s2_sqx} + {1'b0, r_s2_sqy};
        r_s3_chk  <= r_s2_chk;
        r_s3_addr <= r_s2_addr;
        r_side[0].chk     <= r_s3_chk;
        r_side[0].in_disc <= (r_s3_d2 < {4'd0, r_rad2});
        r_side[0].inring  <= (r_s3_d2 < {4'd0, r_ring2});
        r_side[0].addr    <= r_s3_addr;
        for (int i = 1; i < 5; i++) begin
            r_side[i] <= r_side[i-1];
        end
    end

    // Color selection: background, disc or ring.
    assign base5_p  = w_base * 8'd205;
    assign base3_p  = w_base * 8'd171;
    assign shade5_p = w_shade * 8'd205;

    always_comb begin
        if (r_side[4].in_disc) begin
            col_r = 8'd64 + {1'b0, w_shade[7:1]};
            col_g = 8'd188 + {2'd0, shade5_p[15:10]};
            col_b = 8'd220 + {3'd0, w_shade[7:3]};
        end else if (r_side[4].inring) begin
            col_r = 8'd240;
            col_g = 8'd160 + {2'd0, w_rip[7:2]};
            col_b = 8'd58;
        end else begin
            col_r = 8'd18 + {2'd0, base5_p[15:10]};
            col_g = 8'd24 + {2'd0, w_glow[7:2]};
            col_b = 8'd42 + {1'b0, base3_p[15:9]} + (r_side[4].chk ? 8'd16 : 8'd0);
        end
    end

    // Result register: one beat per strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_base_vld & w_glow_vld & w_shade_vld & w_rip_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_pixel_value   <= {col_r[7:3], col_g[7:2], col_b[7:3]};
        o_pixel_address <= r_side[4].addr;
    end

endmodule

// ----- sv/atp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atp_checker: port-level checks for the test pattern generator
// Latency of results, setup after configuration and after reset.
// ----------------------------------------------------------------------------
module atp_checker
    import atp_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_cfg_valid,
    input logic o_cfg_ready,
    input logic o_valid
);

    // Every accepted beat yields a result strobe.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##10 o_valid)
        else $error("accepted beat produced no result");

    // No result strobe without an earlier accepted beat.
    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 10))
        else $error("result strobe without an accepted beat");

    // A configuration write starts the setup sequence.
    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> busy)
        else $error("busy not raised after configuration write");

    // Setup runs right after reset is released.
    a_rst_busy: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> busy)
        else $error("busy low right after reset");

endmodule

bind animated_test_pattern_pixel_top atp_checker u_atp_checker (.*);
